// ===== rtl/core/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types, codes and default sizes of the bounded shift deque.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Default sizes of the list.
  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned ENTRY_BITS_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COUNT_W = 9;

  // Number of cells that one selection group gathers in its first stage.
  localparam int unsigned GROUP_SIZE = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_HEAD = 3'd0,
    ACT_PUSH_TAIL = 3'd1,
    ACT_POP_HEAD  = 3'd2,
    ACT_POP_TAIL  = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  // Command that every cell of the row sees in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_PUSH_HEAD = 2'd1,
    CELL_PUSH_TAIL = 2'd2,
    CELL_POP_HEAD  = 2'd3
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_REDUCE = 3'b100
  } state_e;

endpackage

// ===== rtl/core/bsd_ifs.sv =====
// ----------------------------------------------------------------------------
// bsd_ifs
// Valid/ready channels that carry request and result words of the deque.
// ----------------------------------------------------------------------------
interface bsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsd_pkg::ACT_W-1:0]   action;
  logic [bsd_pkg::WORD_W-1:0]  entry_data;
  logic [bsd_pkg::IDX_W-1:0]   read_index;

  modport source (output valid, action, entry_data, read_index, input ready);
  modport sink   (input valid, action, entry_data, read_index, output ready);
endinterface

interface bsd_out_if;
  logic                         valid;
  logic                         ready;
  logic [bsd_pkg::COUNT_W-1:0]  list_count;
  logic                         rejected;
  logic                         read_valid;
  logic [bsd_pkg::WORD_W-1:0]   read_word;
  logic [bsd_pkg::WORD_W-1:0]   head_word;
  logic [bsd_pkg::WORD_W-1:0]   tail_word;

  modport source (output valid, list_count, rejected, read_valid, read_word, head_word,
                  tail_word, input ready);
  modport sink   (input valid, list_count, rejected, read_valid, read_word, head_word,
                  tail_word, output ready);
endinterface

// ===== rtl/core/bounded_shift_deque.sv =====
// A request word is taken only while idle, and the next one only after its result word has
// loaded into the output register, which waits for a free output; the result passes the
// two-level selection tree that picks the tail and read entries out of the cell row.
// Reset clears the entry count; the cell row itself is not cleared and only
// cells below the count are ever reported.
// ----------------------------------------------------------------------------
// bounded_shift_deque
// Fixed-capacity ordered list held in a row of shifting cells.
// ----------------------------------------------------------------------------
module bounded_shift_deque #(
  parameter int unsigned CAPACITY   = bsd_pkg::CAPACITY_DEF,
  parameter int unsigned ENTRY_BITS = bsd_pkg::ENTRY_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsd_in_if.sink        in_chan_i,
  bsd_out_if.source     out_chan_o
);

  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned GROUP_SIZE = bsd_pkg::GROUP_SIZE;
  localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;
  localparam int unsigned POS_W      = $clog2(PAD_DEPTH + 1);
  localparam int unsigned IDX_W      = bsd_pkg::IDX_W;
  localparam int unsigned CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned WORD_W     = bsd_pkg::WORD_W;
  localparam int unsigned COUNT_W    = bsd_pkg::COUNT_W;

  bsd_pkg::state_e       state_d, state_q;
  logic [CNT_W-1:0]      count_d, count_q;
  logic                  rejected_d, rejected_q;
  logic                  read_valid_d, read_valid_q;
  logic [POS_W-1:0]      tail_pos_q, read_pos_q;
  bsd_pkg::cell_op_e     cell_op;
  logic [ENTRY_BITS-1:0] new_word;
  logic                  accept;
  logic                  full, empty;

  logic [ENTRY_BITS-1:0] cell_words [CAPACITY];
  logic [ENTRY_BITS-1:0] pad_words  [PAD_DEPTH];
  logic [ENTRY_BITS-1:0] tail_parts [NUM_GROUPS];
  logic [ENTRY_BITS-1:0] read_parts [NUM_GROUPS];
  logic [ENTRY_BITS-1:0] tail_all, read_all;

  logic                  out_valid_d, out_valid_q;
  logic                  out_load;
  logic [COUNT_W-1:0]    out_count_q;
  logic                  out_rejected_q, out_read_valid_q;
  logic [WORD_W-1:0]     out_read_q, out_head_q, out_tail_q;

  assign in_chan_i.ready = (state_q == bsd_pkg::ST_IDLE);
  assign accept          = in_chan_i.valid && in_chan_i.ready;
  assign new_word        = ENTRY_BITS'(in_chan_i.entry_data);
  assign full            = (count_q == CNT_W'(CAPACITY));
  assign empty           = (count_q == '0);

  // Decode the request word into a row command and the new count.
  always_comb begin
    cell_op      = bsd_pkg::CELL_HOLD;
    count_d      = count_q;
    rejected_d   = 1'b0;
    read_valid_d = 1'b0;
    if (accept) begin
      unique case (in_chan_i.action)
        bsd_pkg::ACT_PUSH_HEAD: begin
          if (full) begin
            rejected_d = 1'b1;
          end else begin
            cell_op = bsd_pkg::CELL_PUSH_HEAD;
            count_d = count_q + CNT_W'(1);
          end
        end
        bsd_pkg::ACT_PUSH_TAIL: begin
          if (full) begin
            rejected_d = 1'b1;
          end else begin
            cell_op = bsd_pkg::CELL_PUSH_TAIL;
            count_d = count_q + CNT_W'(1);
          end
        end
        bsd_pkg::ACT_POP_HEAD: begin
          if (empty) begin
            rejected_d = 1'b1;
          end else begin
            cell_op = bsd_pkg::CELL_POP_HEAD;
            count_d = count_q - CNT_W'(1);
          end
        end
        bsd_pkg::ACT_POP_TAIL: begin
          if (empty) begin
            rejected_d = 1'b1;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        bsd_pkg::ACT_READ: begin
          read_valid_d = (CMP_W'(in_chan_i.read_index) < CMP_W'(count_q));
        end
        default: begin
        end
      endcase
    end
  end

  // Row of cells; each one looks only at its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_BITS-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = cell_words[i];
    end else begin : g_inner_lo
      assign lower = cell_words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_words[i];
    end else begin : g_inner_hi
      assign upper = cell_words[i+1];
    end

    bsd_cell #(
      .ENTRY_BITS (ENTRY_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .word_i  (new_word),
      .count_i (count_q),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (cell_words[i])
    );
  end

  for (genvar j = 0; j < PAD_DEPTH; j++) begin : g_pad
    if (j < CAPACITY) begin : g_real
      assign pad_words[j] = cell_words[j];
    end else begin : g_zero
      assign pad_words[j] = '0;
    end
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    bsd_sel_group #(
      .ENTRY_BITS (ENTRY_BITS),
      .GROUP_SIZE (GROUP_SIZE),
      .POS_W      (POS_W),
      .BASE       (g * GROUP_SIZE)
    ) u_group (
      .clk_i       (clk_i),
      .words_i     (pad_words[g*GROUP_SIZE +: GROUP_SIZE]),
      .tail_pos_i  (tail_pos_q),
      .read_pos_i  (read_pos_q),
      .tail_part_o (tail_parts[g]),
      .read_part_o (read_parts[g])
    );
  end

  // Second selection stage: only the matching group contributes.
  always_comb begin
    tail_all = '0;
    read_all = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      tail_all = tail_all | tail_parts[g];
      read_all = read_all | read_parts[g];
    end
  end

  assign out_load = (state_q == bsd_pkg::ST_REDUCE) && (!out_valid_q || out_chan_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsd_pkg::ST_IDLE:   if (accept) state_d = bsd_pkg::ST_GATHER;
      bsd_pkg::ST_GATHER: state_d = bsd_pkg::ST_REDUCE;
      bsd_pkg::ST_REDUCE: if (out_load) state_d = bsd_pkg::ST_IDLE;
      default:            state_d = bsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsd_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-word flags and selection positions, captured when the word is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rejected_q   <= rejected_d;
      read_valid_q <= read_valid_d;
      tail_pos_q   <= POS_W'(count_d - CNT_W'(1));
      read_pos_q   <= POS_W'(in_chan_i.read_index);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q      <= COUNT_W'(count_q);
      out_rejected_q   <= rejected_q;
      out_read_valid_q <= read_valid_q;
      out_read_q       <= read_valid_q ? WORD_W'(read_all) : '0;
      out_head_q       <= empty ? '0 : WORD_W'(cell_words[0]);
      out_tail_q       <= empty ? '0 : WORD_W'(tail_all);
    end
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.list_count = out_count_q;
  assign out_chan_o.rejected   = out_rejected_q;
  assign out_chan_o.read_valid = out_read_valid_q;
  assign out_chan_o.read_word  = out_read_q;
  assign out_chan_o.head_word  = out_head_q;
  assign out_chan_o.tail_word  = out_tail_q;

endmodule

// ===== rtl/core/bsd_cell.sv =====
// ----------------------------------------------------------------------------
// bsd_cell
// One storage cell of the row: holds, loads, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module bsd_cell #(
  parameter int unsigned ENTRY_BITS = bsd_pkg::ENTRY_BITS_DEF,
  parameter int unsigned CNT_W      = 9,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  bsd_pkg::cell_op_e     op_i,
  input  logic [ENTRY_BITS-1:0] word_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [ENTRY_BITS-1:0] lower_i,
  input  logic [ENTRY_BITS-1:0] upper_i,
  output logic [ENTRY_BITS-1:0] word_o
);

  logic [ENTRY_BITS-1:0] word_d, word_q;

  always_comb begin
    unique case (op_i)
      bsd_pkg::CELL_PUSH_HEAD: word_d = (INDEX == 0) ? word_i : lower_i;
      bsd_pkg::CELL_PUSH_TAIL: word_d = (count_i == CNT_W'(INDEX)) ? word_i : word_q;
      bsd_pkg::CELL_POP_HEAD:  word_d = upper_i;
      default:                 word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/bsd_sel_group.sv =====
// ----------------------------------------------------------------------------
// bsd_sel_group
// First selection stage: picks the tail and read entries within one group.
// ----------------------------------------------------------------------------
module bsd_sel_group #(
  parameter int unsigned ENTRY_BITS = bsd_pkg::ENTRY_BITS_DEF,
  parameter int unsigned GROUP_SIZE = bsd_pkg::GROUP_SIZE,
  parameter int unsigned POS_W      = 9,
  parameter int unsigned BASE       = 0
) (
  input  logic                  clk_i,
  input  logic [ENTRY_BITS-1:0] words_i [GROUP_SIZE],
  input  logic [POS_W-1:0]      tail_pos_i,
  input  logic [POS_W-1:0]      read_pos_i,
  output logic [ENTRY_BITS-1:0] tail_part_o,
  output logic [ENTRY_BITS-1:0] read_part_o
);

  logic [ENTRY_BITS-1:0] tail_part_d, tail_part_q;
  logic [ENTRY_BITS-1:0] read_part_d, read_part_q;

  // At most one cell matches each position, so an AND-OR picks it.
  always_comb begin
    tail_part_d = '0;
    read_part_d = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      if (POS_W'(BASE + k) == tail_pos_i) tail_part_d = tail_part_d | words_i[k];
      if (POS_W'(BASE + k) == read_pos_i) read_part_d = read_part_d | words_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    tail_part_q <= tail_part_d;
    read_part_q <= read_part_d;
  end

  assign tail_part_o = tail_part_q;
  assign read_part_o = read_part_q;

endmodule

// ===== tb/tb_bounded_shift_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_shift_deque
// Drives request words into the deque under varied flow control, tracks the
// expected list contents alongside, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_bounded_shift_deque;
  import bsd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 388;
  localparam int unsigned TRAIL_CYCLES    = 8;

  // Action codes that the block must ignore.
  localparam logic [ACT_W-1:0] ACT_RSVD_MIN = ACT_W'(ACT_READ + 1);
  localparam logic [ACT_W-1:0] ACT_RSVD_MAX = '1;

  typedef struct packed {
    logic [COUNT_W-1:0] list_count;
    logic               rejected;
    logic               read_valid;
    logic [WORD_W-1:0]  read_word;
    logic [WORD_W-1:0]  head_word;
    logic [WORD_W-1:0]  tail_word;
  } list_result_t;

  class deque_tracker;
    logic [WORD_W-1:0] entries [CAPACITY_DEF];
    int unsigned       list_size;
    list_result_t      expected_results [$];
    int unsigned       mismatch_count;

    function new();
      list_size      = 0;
      mismatch_count = 0;
    endfunction

    // Applies one accepted request to the tracked list and queues its result.
    function void note_request(logic [ACT_W-1:0] act, logic [WORD_W-1:0] data,
                               logic [IDX_W-1:0] idx);
      list_result_t want;
      int unsigned  i;
      want = '0;
      case (act)
        ACT_PUSH_HEAD: begin
          if (list_size >= CAPACITY_DEF) begin
            want.rejected = 1'b1;
          end else begin
            for (i = list_size; i > 0; i--) entries[i] = entries[i-1];
            entries[0] = data;
            list_size++;
          end
        end
        ACT_PUSH_TAIL: begin
          if (list_size >= CAPACITY_DEF) begin
            want.rejected = 1'b1;
          end else begin
            entries[list_size] = data;
            list_size++;
          end
        end
        ACT_POP_HEAD: begin
          if (list_size == 0) begin
            want.rejected = 1'b1;
          end else begin
            for (i = 0; i + 1 < list_size; i++) entries[i] = entries[i+1];
            list_size--;
          end
        end
        ACT_POP_TAIL: begin
          if (list_size == 0) want.rejected = 1'b1;
          else list_size--;
        end
        ACT_READ: begin
          if (idx < list_size) begin
            want.read_valid = 1'b1;
            want.read_word  = entries[idx];
          end
        end
        default: ;
      endcase
      want.list_count = list_size[COUNT_W-1:0];
      if (list_size != 0) begin
        want.head_word = entries[0];
        want.tail_word = entries[list_size-1];
      end
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, got);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("list_count", want.list_count, got.list_count);
      compare_field("rejected", want.rejected, got.rejected);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("read_word", want.read_word, got.read_word);
      compare_field("head_word", want.head_word, got.head_word);
      compare_field("tail_word", want.tail_word, got.tail_word);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bsd_in_if  in_if ();
  bsd_out_if out_if ();

  bounded_shift_deque i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if)
  );

  deque_tracker tracker;
  int unsigned  src_idle_pct;
  int unsigned  sink_stall_pct;
  logic         grow_list;
  int unsigned  stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && tracker != null && out_if.valid && out_if.ready) begin
      tracker.check_result('{list_count: out_if.list_count, rejected: out_if.rejected,
                             read_valid: out_if.read_valid, read_word: out_if.read_word,
                             head_word: out_if.head_word, tail_word: out_if.tail_word});
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb_bounded_shift_deque failed");
    $finish;
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] data,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.entry_data <= data;
    in_if.read_index <= idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.note_request(act, data, idx);
    @(negedge clk_i);
  endtask

  // Mostly grows the list toward full, then drains it toward empty, so that
  // both limits and the rejects at them are reached repeatedly.
  task automatic send_random_word();
    int unsigned       size;
    int unsigned       roll;
    logic [ACT_W-1:0]  act;
    logic [WORD_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    size = tracker.list_size;
    if (size == CAPACITY_DEF && $urandom_range(3) == 0) grow_list = 1'b0;
    else if (size == 0 && $urandom_range(3) == 0) grow_list = 1'b1;
    data = $urandom();
    case ($urandom_range(7))
      0: data = '0;
      1: data = '1;
      default: ;
    endcase
    idx  = IDX_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 3) begin
      act = ACT_W'($urandom_range(ACT_RSVD_MAX, ACT_RSVD_MIN));
    end else if (roll < 18) begin
      act = ACT_READ;
      if (size != 0 && $urandom_range(9) != 0) idx = IDX_W'($urandom_range(size - 1));
    end else if (($urandom_range(99) < 85) == grow_list) begin
      act = $urandom_range(1) ? ACT_PUSH_HEAD : ACT_PUSH_TAIL;
    end else begin
      act = $urandom_range(1) ? ACT_POP_HEAD : ACT_POP_TAIL;
    end
    send_word(act, data, idx);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned idle_src [4];
    int unsigned idle_sink [4];
    int          code;
    idle_src  = '{0, 79, 0, 19};
    idle_sink = '{0, 0, 79, 19};
    tracker          = new();
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    grow_list        = 1'b1;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = ACT_READ;
    in_if.entry_data = '0;
    in_if.read_index = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: reads miss, removes are rejected, unused codes do nothing.
    send_word(ACT_READ, '0, '0);
    send_word(ACT_READ, '1, '1);
    send_word(ACT_POP_HEAD, '0, '0);
    send_word(ACT_POP_TAIL, '0, '0);
    for (code = ACT_RSVD_MIN; code <= ACT_RSVD_MAX; code++) begin
      send_word(code[ACT_W-1:0], '1, '0);
    end
    send_word(ACT_PUSH_HEAD, '1, '0);
    send_word(ACT_PUSH_TAIL, '0, '1);
    send_word(ACT_PUSH_HEAD, 32'h5a5a_a5a5, '0);
    send_word(ACT_PUSH_TAIL, 32'h8000_0001, '0);
    send_word(ACT_READ, '0, 8'd0);
    send_word(ACT_READ, '0, 8'd3);
    send_word(ACT_READ, '0, 8'd4);
    send_word(ACT_READ, '0, '1);
    send_word(ACT_RSVD_MAX, 32'h1234_5678, 8'd1);
    send_word(ACT_POP_HEAD, '0, '0);
    send_word(ACT_POP_TAIL, '0, '0);
    send_word(ACT_READ, '0, 8'd1);
    send_word(ACT_POP_TAIL, '0, '0);
    send_word(ACT_POP_HEAD, '0, '0);
    send_word(ACT_READ, '0, 8'd0);
    wait_for_results();

    // Each phase ends with the sender held off until every result is back.
    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct   = idle_src[phase];
      sink_stall_pct = idle_sink[phase];
      repeat (ITEMS_PER_PHASE) send_random_word();
      wait_for_results();
    end

    repeat (TRAIL_CYCLES) @(negedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.expected_results.size() == 0) begin
      $display("tb_bounded_shift_deque passed");
    end else begin
      $display("tb_bounded_shift_deque failed");
    end
    $finish;
  end

endmodule
